// ===== rtl/core/lbs_pkg.sv =====
// Shared constants for the longest bitonic subsequence block.
// No dependencies; imported by lbs_ram users and the top level.
`default_nettype none
package lbs_pkg;
    localparam int MAX_LEN    = 256;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int VALUE_W    = 32;
    localparam int LENGTH_W   = 9;
    localparam int LENGTH_MAX = 2 ** LENGTH_W - 1;
    localparam int OUT_DATA_W = ((LENGTH_W + 7) / 8) * 8;
endpackage
`default_nettype wire

// ===== rtl/core/lbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
`default_nettype none
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/longest_bitonic_subsequence.sv =====
// Longest bitonic subsequence: top level with loader, sequencer and DP passes.
// Depends on lbs_pkg and lbs_ram (element, rise and fall stores).
//
// Usage:
//   The slave channel takes one signed 32-bit element per transfer in s_tdata;
//   s_tlast marks the final element of a sequence. Elements load one per cycle.
//   Up to MAX_LEN elements are kept; later ones are dropped and flagged.
//   After the last transfer the block runs a forward pass (longest rising run
//   ending at each element) and a backward pass (longest falling run starting
//   at each element) with one shared compare/add unit that visits one stored
//   pair per cycle, reading the element and length stores through their single
//   read ports. s_tready stays low through the passes and the result transfer.
//   The result leaves on the master channel: length in m_tdata, the dropped
//   flag in m_tuser. It is held until m_tready; no new element is taken until
//   the result transfer completes.
//   Reset clears the element count, the dropped flag and the sequencer; the
//   stores need no clearing since only written entries are read.
`default_nettype none
module longest_bitonic_subsequence (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lbs_pkg::VALUE_W-1:0]      s_tdata,  // [31:0] value
    input  wire logic                             s_tlast,  // last
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [lbs_pkg::OUT_DATA_W-1:0]   m_tdata,  // [8:0] length, rest zero
    output logic                                  m_tuser   // overflow
);
    import lbs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_F_I  = 3'd1;
    localparam logic [2:0] ST_F_IH = 3'd2;
    localparam logic [2:0] ST_F_J  = 3'd3;
    localparam logic [2:0] ST_B_I  = 3'd4;
    localparam logic [2:0] ST_B_IH = 3'd5;
    localparam logic [2:0] ST_B_J  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam int WIDE_W = CNT_W + LENGTH_W;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               drop_reg, drop_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   best_reg, best_next;
    logic [VALUE_W-1:0] ei_reg, ei_next;
    logic [CNT_W-1:0]   ri_reg, ri_next;

    logic               e_we;
    logic [ADDR_W-1:0]  e_waddr, e_raddr;
    logic [VALUE_W-1:0] e_rdata;
    logic               r_we;
    logic [ADDR_W-1:0]  r_raddr;
    logic [CNT_W-1:0]   r_rdata;
    logic               f_we;
    logic [ADDR_W-1:0]  f_raddr;
    logic [CNT_W-1:0]   f_rdata;

    logic               in_fire;
    logic               has_room;
    logic [CNT_W-1:0]   cand;
    logic [CNT_W:0]     total;
    logic [WIDE_W-1:0]  best_wide;
    logic [LENGTH_W-1:0] length_sat;

    lbs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN)) u_elem (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (s_tdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    lbs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_rise (
        .clk   (clk),
        .we    (r_we),
        .waddr (i_reg[ADDR_W-1:0]),
        .wdata (acc_reg),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    lbs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_fall (
        .clk   (clk),
        .we    (f_we),
        .waddr (i_reg[ADDR_W-1:0]),
        .wdata (acc_reg),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign has_room = (count_reg < CNT_W'(MAX_LEN));
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = ovf_reg;

    assign best_wide  = WIDE_W'(best_reg);
    assign length_sat = (best_wide > WIDE_W'(LENGTH_MAX)) ? LENGTH_W'(LENGTH_MAX)
                                                         : best_wide[LENGTH_W-1:0];
    assign m_tdata    = OUT_DATA_W'(length_sat);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        best_next  = best_reg;
        ei_next    = ei_reg;
        ri_next    = ri_reg;
        e_we       = 1'b0;
        e_waddr    = count_reg[ADDR_W-1:0];
        e_raddr    = i_reg[ADDR_W-1:0];
        r_we       = 1'b0;
        r_raddr    = i_reg[ADDR_W-1:0];
        f_we       = 1'b0;
        f_raddr    = j_reg[ADDR_W-1:0];
        cand       = (state_reg == ST_B_J) ? f_rdata + CNT_W'(1) : r_rdata + CNT_W'(1);
        total      = (CNT_W + 1)'(ri_reg) + (CNT_W + 1)'(acc_reg) - (CNT_W + 1)'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        e_we       = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        n_next     = has_room ? count_reg + CNT_W'(1) : count_reg;
                        ovf_next   = drop_reg || !has_room;
                        count_next = '0;
                        drop_next  = 1'b0;
                        i_next     = '0;
                        best_next  = '0;
                        state_next = ST_F_I;
                    end
                end
            end
            ST_F_I:
            begin
                state_next = ST_F_IH;
            end
            ST_F_IH:
            begin
                ei_next    = e_rdata;
                acc_next   = CNT_W'(1);
                j_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_F_J;
            end
            ST_F_J:
            begin
                if (pend_reg && ($signed(e_rdata) < $signed(ei_reg)) && (cand > acc_reg))
                begin
                    acc_next = cand;
                end
                e_raddr = j_reg[ADDR_W-1:0];
                r_raddr = j_reg[ADDR_W-1:0];
                if (j_reg < i_reg)
                begin
                    j_next    = j_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        r_we = 1'b1;
                        if (i_reg + CNT_W'(1) == n_reg)
                        begin
                            i_next     = n_reg - CNT_W'(1);
                            state_next = ST_B_I;
                        end
                        else
                        begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = ST_F_I;
                        end
                    end
                end
            end
            ST_B_I:
            begin
                state_next = ST_B_IH;
            end
            ST_B_IH:
            begin
                ei_next    = e_rdata;
                ri_next    = r_rdata;
                acc_next   = CNT_W'(1);
                j_next     = i_reg + CNT_W'(1);
                pend_next  = 1'b0;
                state_next = ST_B_J;
            end
            ST_B_J:
            begin
                if (pend_reg && ($signed(e_rdata) < $signed(ei_reg)) && (cand > acc_reg))
                begin
                    acc_next = cand;
                end
                e_raddr = j_reg[ADDR_W-1:0];
                if (j_reg < n_reg)
                begin
                    j_next    = j_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        f_we = 1'b1;
                        if (total > (CNT_W + 1)'(best_reg))
                        begin
                            best_next = total[CNT_W-1:0];
                        end
                        if (i_reg == '0)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            i_next     = i_reg - CNT_W'(1);
                            state_next = ST_B_I;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg  <= ovf_next;
        n_reg    <= n_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        acc_reg  <= acc_next;
        best_reg <= best_next;
        ei_reg   <= ei_next;
        ri_reg   <= ri_next;
    end
endmodule
`default_nettype wire
